/* hw/rtl/grm_pkg.sv */
// ----------------------------------------------------------------------------
// grm_pkg
// Shared types and codes for the grid ray march block.
// ----------------------------------------------------------------------------
package grm_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 22;
   localparam int CELL_W    = 6;
   localparam int TRIG_W    = 32;

   // Internal position width: covers the map, one overshoot step and sign.
   localparam int WPOS_W    = 40;
   localparam int GAP_W     = FRAC_BITS + 1;
   localparam int MUL_A_W   = GAP_W + 1;
   localparam int MUL_B_W   = TRIG_W + 1;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int WCELL_W   = 11;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_CAST  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_HIT       = 2'd0,
      STATUS_LEFT_MAP  = 2'd1,
      STATUS_STEP_LIM  = 2'd2,
      STATUS_WRITE_DONE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_START,
      ST_BORDER,
      ST_MULA,
      ST_CMP,
      ST_MULB,
      ST_UPDATE,
      ST_CHECK,
      ST_TEST
   } state_type;

endpackage

/* hw/rtl/grid_ray_march.sv */
// ----------------------------------------------------------------------------
// grid_ray_march
// Grid ray caster over a square bit map of wall cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per item. req_type REQ_WRITE sets or clears one map
//   cell; REQ_CAST marches a ray from (start_x, start_y) border to border until
//   it enters a wall cell, leaves the map or runs MAX_STEPS crossings.
//   rsp_* returns exactly one word per request: hit point, cell, side, status.
// Sequence:
//   A write passes through ST_WRITE. A cast passes through ST_START, then
//   for each border crossing: border calc, first pass through the one shared
//   18x33 multiplier, compare, second pass, update, bounds check, map read.
//   One item is in work at a time; req_stall is high until its result is
//   loaded into the output register.
// Reset:
//   Synchronous, active high. After reset the map is swept clear, one cell per
//   cycle, over all MAP_SIDE*MAP_SIDE cells (side rounded up to a power of two),
//   with req_stall held high.
// Receiver stall:
//   The result sits in the output register while rsp_stall is high; the next
//   request can still be taken, and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module grid_ray_march #(
   parameter int MAP_SIDE  = 64,
   parameter int MAX_STEPS = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [grm_pkg::CELL_W-1:0]         req_cell_x,
   input  logic [grm_pkg::CELL_W-1:0]         req_cell_y,
   input  logic                               req_wall_bit,
   input  logic [grm_pkg::POS_W-1:0]          req_start_x,
   input  logic [grm_pkg::POS_W-1:0]          req_start_y,
   input  logic                               req_cos_positive,
   input  logic                               req_sin_positive,
   input  logic                               req_cos_zero,
   input  logic                               req_sin_zero,
   input  logic signed [grm_pkg::TRIG_W-1:0]  req_tan_value,
   input  logic signed [grm_pkg::TRIG_W-1:0]  req_cot_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [grm_pkg::POS_W-1:0]          rsp_hit_x,
   output logic [grm_pkg::POS_W-1:0]          rsp_hit_y,
   output logic [grm_pkg::CELL_W-1:0]         rsp_hit_cell_x,
   output logic [grm_pkg::CELL_W-1:0]         rsp_hit_cell_y,
   output logic                               rsp_hit_side,
   output logic [1:0]                         rsp_status
);
   import grm_pkg::*;

   localparam int CW      = $clog2(MAP_SIDE);
   localparam int AW      = 2 * CW;
   localparam int CELLS   = 1 << AW;
   localparam int STEP_W  = $clog2(MAX_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_STEPS - 1);
   localparam logic signed [WPOS_W-1:0] ONE   = WPOS_W'(64'd1 << FRAC_BITS);
   localparam logic signed [WPOS_W-1:0] LIMIT = WPOS_W'(64'(MAP_SIDE) << FRAC_BITS);
   localparam logic signed [WCELL_W-1:0] SIDE_C = WCELL_W'(MAP_SIDE);

   // control
   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // item and march registers
   logic [CELL_W-1:0]      wr_x_ff, wr_x_in, wr_y_ff, wr_y_in;
   logic                   wr_bit_ff, wr_bit_in;
   logic                   cpos_ff, cpos_in, spos_ff, spos_in;
   logic                   czero_ff, czero_in, szero_ff, szero_in;
   logic signed [MUL_B_W-1:0] tan_ff, tan_in, cot_ff, cot_in, atan_ff, atan_in;
   logic signed [WPOS_W-1:0]  x_ff, x_in, y_ff, y_in, nx_ff, nx_in, ny_ff, ny_in;
   logic signed [WCELL_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [GAP_W-1:0]       gx_ff, gx_in, gy_ff, gy_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic                   cross_ff, cross_in;
   logic                   rd_ff;

   // result register
   logic [POS_W-1:0]       hit_x_ff, hit_x_in, hit_y_ff, hit_y_in;
   logic [CELL_W-1:0]      hcx_ff, hcx_in, hcy_ff, hcy_in;
   logic                   side_ff, side_in;
   status_type             status_ff, status_in;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;

   // map memory
   logic                   wall_mem [0:CELLS-1];
   logic                   mem_we, mem_wdata;
   logic [AW-1:0]          mem_waddr, rd_addr;

   // helpers
   logic                   slot_free;
   logic                   wr_in_map;
   logic signed [WPOS_W-1:0] bx, by, bnx, bny, move, delta;
   logic signed [MUL_B_W-1:0] tan_ext;
   logic [8:0]             ext_wx, ext_wy, ext_sx;
   logic                   out_of_map;

   assign mul_p = mul_a * mul_b;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign ext_wx = 9'(wr_x_ff);
   assign ext_wy = 9'(wr_y_ff);
   assign ext_sx = 9'(x_ff[FRAC_BITS +: CELL_W]);
   assign wr_in_map = (ext_wx < 9'(MAP_SIDE)) && (ext_wy < 9'(MAP_SIDE));
   assign rd_addr = {cy_ff[CW-1:0], cx_ff[CW-1:0]};
   assign move = WPOS_W'(prod_ff >>> FRAC_BITS);
   assign delta = cross_ff ? (nx_ff - x_ff) : (ny_ff - y_ff);
   assign tan_ext = MUL_B_W'(req_tan_value);
   assign out_of_map = x_ff < 0 || x_ff > LIMIT || y_ff < 0 || y_ff > LIMIT ||
                       cx_ff < 0 || cx_ff >= SIDE_C || cy_ff < 0 || cy_ff >= SIDE_C;

   // next border on each axis from the current (non-negative) position
   always_comb begin
      bx = {x_ff[WPOS_W-1:FRAC_BITS], FRAC_BITS'(0)};
      by = {y_ff[WPOS_W-1:FRAC_BITS], FRAC_BITS'(0)};
      if (cpos_ff) begin
         bnx = bx + ONE;
      end else if (x_ff[FRAC_BITS-1:0] != '0) begin
         bnx = bx;
      end else begin
         bnx = bx - ONE;
      end
      if (spos_ff) begin
         bny = by + ONE;
      end else if (y_ff[FRAC_BITS-1:0] != '0) begin
         bny = by;
      end else begin
         bny = by - ONE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_x_in = wr_x_ff;  wr_y_in = wr_y_ff;  wr_bit_in = wr_bit_ff;
      cpos_in = cpos_ff;  spos_in = spos_ff;
      czero_in = czero_ff; szero_in = szero_ff;
      tan_in = tan_ff;  cot_in = cot_ff;  atan_in = atan_ff;
      x_in = x_ff;  y_in = y_ff;  nx_in = nx_ff;  ny_in = ny_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  gx_in = gx_ff;  gy_in = gy_ff;
      prod_in = prod_ff;  cross_in = cross_ff;
      hit_x_in = hit_x_ff;  hit_y_in = hit_y_ff;
      hcx_in = hcx_ff;  hcy_in = hcy_ff;  side_in = side_ff;
      status_in = status_ff;
      mem_we = 1'b0;  mem_waddr = clr_ff;  mem_wdata = 1'b0;
      mul_a = MUL_A_W'(gx_ff);
      mul_b = atan_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               wr_x_in = req_cell_x;  wr_y_in = req_cell_y;  wr_bit_in = req_wall_bit;
               cpos_in = req_cos_positive;  spos_in = req_sin_positive;
               czero_in = req_cos_zero;  szero_in = req_sin_zero;
               tan_in = tan_ext;
               cot_in = MUL_B_W'(req_cot_value);
               atan_in = tan_ext[MUL_B_W-1] ? -tan_ext : tan_ext;
               x_in = WPOS_W'(req_start_x);
               y_in = WPOS_W'(req_start_y);
               cx_in = WCELL_W'(req_start_x[FRAC_BITS +: CELL_W]);
               cy_in = WCELL_W'(req_start_y[FRAC_BITS +: CELL_W]);
               step_in = '0;
               state_in = (req_type == REQ_WRITE) ? ST_WRITE : ST_START;
            end
         end
         ST_WRITE: begin
            mem_we    = wr_in_map;
            mem_waddr = {wr_y_ff[CW-1:0], wr_x_ff[CW-1:0]};
            mem_wdata = wr_bit_ff;
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               hit_x_in = '0;  hit_y_in = '0;  hcx_in = '0;  hcy_in = '0;  side_in = 1'b0;
               status_in = STATUS_WRITE_DONE;
               state_in = ST_IDLE;
            end
         end
         ST_START: begin
            // start cell is checked for range only, never for a wall
            if (ext_sx < 9'(MAP_SIDE) && 9'(cy_ff[CELL_W-1:0]) < 9'(MAP_SIDE)) begin
               state_in = ST_BORDER;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               hit_x_in = '0;  hit_y_in = '0;  hcx_in = '0;  hcy_in = '0;  side_in = 1'b0;
               status_in = STATUS_LEFT_MAP;
               state_in = ST_IDLE;
            end
         end
         ST_BORDER: begin
            nx_in = bnx;
            ny_in = bny;
            gx_in = GAP_W'(cpos_ff ? bnx - x_ff : x_ff - bnx);
            gy_in = GAP_W'(spos_ff ? bny - y_ff : y_ff - bny);
            state_in = ST_MULA;
         end
         ST_MULA: begin
            prod_in  = mul_p;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (czero_ff) begin
               cross_in = 1'b0;
            end else if (szero_ff) begin
               cross_in = 1'b1;
            end else begin
               cross_in = prod_ff < $signed(PROD_W'({gy_ff, FRAC_BITS'(0)}));
            end
            state_in = ST_MULB;
         end
         ST_MULB: begin
            mul_a    = MUL_A_W'(delta);
            mul_b    = cross_ff ? tan_ff : cot_ff;
            prod_in  = mul_p;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (czero_ff) begin
               y_in  = ny_ff;
               cy_in = spos_ff ? ny_ff[FRAC_BITS +: WCELL_W]
                               : ny_ff[FRAC_BITS +: WCELL_W] - 1'b1;
            end else if (cross_ff) begin
               y_in  = y_ff + move;
               x_in  = nx_ff;
               cx_in = cpos_ff ? nx_ff[FRAC_BITS +: WCELL_W]
                               : nx_ff[FRAC_BITS +: WCELL_W] - 1'b1;
            end else begin
               x_in  = x_ff + move;
               y_in  = ny_ff;
               cy_in = spos_ff ? ny_ff[FRAC_BITS +: WCELL_W]
                               : ny_ff[FRAC_BITS +: WCELL_W] - 1'b1;
            end
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // map read issued here, also when out of range; data lands in rd_ff
            if (!out_of_map) begin
               state_in = ST_TEST;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               hit_x_in = '0;  hit_y_in = '0;  hcx_in = '0;  hcy_in = '0;  side_in = 1'b0;
               status_in = STATUS_LEFT_MAP;
               state_in = ST_IDLE;
            end
         end
         ST_TEST: begin
            if (rd_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  hit_x_in = x_ff[POS_W-1:0];
                  hit_y_in = y_ff[POS_W-1:0];
                  hcx_in = cx_ff[CELL_W-1:0];
                  hcy_in = cy_ff[CELL_W-1:0];
                  side_in = !cross_ff;
                  status_in = STATUS_HIT;
                  state_in = ST_IDLE;
               end
            end else if (step_ff == LAST_STEP) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  hit_x_in = '0;  hit_y_in = '0;  hcx_in = '0;  hcy_in = '0;  side_in = 1'b0;
                  status_in = STATUS_STEP_LIM;
                  state_in = ST_IDLE;
               end
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_BORDER;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_x_ff <= wr_x_in;  wr_y_ff <= wr_y_in;  wr_bit_ff <= wr_bit_in;
      cpos_ff <= cpos_in;  spos_ff <= spos_in;
      czero_ff <= czero_in;  szero_ff <= szero_in;
      tan_ff <= tan_in;  cot_ff <= cot_in;  atan_ff <= atan_in;
      x_ff <= x_in;  y_ff <= y_in;  nx_ff <= nx_in;  ny_ff <= ny_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  gx_ff <= gx_in;  gy_ff <= gy_in;
      prod_ff <= prod_in;  cross_ff <= cross_in;
      hit_x_ff <= hit_x_in;  hit_y_ff <= hit_y_in;
      hcx_ff <= hcx_in;  hcy_ff <= hcy_in;  side_ff <= side_in;
      status_ff <= status_in;
   end

   // wall map: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         wall_mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_CHECK) begin
         rd_ff <= wall_mem[rd_addr];
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit_x      = hit_x_ff;
   assign rsp_hit_y      = hit_y_ff;
   assign rsp_hit_cell_x = hcx_ff;
   assign rsp_hit_cell_y = hcy_ff;
   assign rsp_hit_side   = side_ff;
   assign rsp_status     = status_ff;

endmodule

/* hw/rtl/grm_checker.sv */
// ----------------------------------------------------------------------------
// grm_checker
// Port-level checks for the grid ray march block.
// ----------------------------------------------------------------------------
module grm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [21:0] rsp_hit_x,
   input logic [21:0] rsp_hit_y,
   input logic        rsp_hit_side,
   input logic [1:0]  rsp_status
);
   import grm_pkg::*;

   // held result word keeps valid, status and hit_x unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_hit_x))
      else $error("rsp word changed while stalled");

   // one item at a time: accept closes the input
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // non-hit results carry zero geometry
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_HIT |->
         rsp_hit_x == '0 && rsp_hit_y == '0 && !rsp_hit_side)
      else $error("non-hit result with geometry");

   // reset starts the map clear: no result, input closed
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("block not quiet after reset");

endmodule

bind grid_ray_march grm_checker u_grm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_hit_x    (rsp_hit_x),
   .rsp_hit_y    (rsp_hit_y),
   .rsp_hit_side (rsp_hit_side),
   .rsp_status   (rsp_status)
);
